[rtl/core/fwup_pkg.sv]
// Shared types and constants for the landing queue with urgent promotion.
// Used by fwup_ctrl, fwup_dpath and the top level; depends on nothing.
package fwup_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int FLIGHT_W = 14;
  localparam int ORIGIN_W = 16;

  localparam logic [CMD_W-1:0] CMD_ARRIVAL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_URGENT  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_LANDED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOBODY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_MOVE = 4'b1000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic do_arrive;
    logic do_drop;
    logic do_clear;
    logic do_nobody;
    logic do_match;
    logic do_step;
    logic do_move;
  } fwup_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             scan_end;
    logic             scan_hit;
    logic             hit_urgent;
    logic             out_busy;
  } fwup_sts_t;

endpackage

[rtl/core/fwup_ctrl.sv]
// Sequencer for the landing queue: accepts a request, then steps the datapath
// through execute and, for an urgent request, scan and move. Depends on fwup_pkg.
module fwup_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 out_tready,
  input  fwup_pkg::fwup_sts_t  sts,
  output fwup_pkg::fwup_ctl_t  ctl
);

  fwup_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fwup_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == fwup_pkg::S_IDLE) && (!sts.out_busy || out_tready);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      fwup_pkg::S_IDLE: begin
        if (in_tvalid && in_tready) begin
          ctl.capture = 1'b1;
          state_nxt   = fwup_pkg::S_EXEC;
        end
      end
      fwup_pkg::S_EXEC: begin
        state_nxt = fwup_pkg::S_IDLE;
        case (sts.cmd)
          fwup_pkg::CMD_ARRIVAL: begin
            ctl.do_drop   = sts.full;
            ctl.do_arrive = !sts.full;
          end
          fwup_pkg::CMD_CLEAR: begin
            ctl.do_nobody = sts.empty;
            ctl.do_clear  = !sts.empty;
          end
          fwup_pkg::CMD_URGENT: begin
            ctl.do_match = 1'b1;
            state_nxt    = fwup_pkg::S_SCAN;
          end
          default: begin
            state_nxt = fwup_pkg::S_IDLE;
          end
        endcase
      end
      fwup_pkg::S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = fwup_pkg::S_IDLE;
        end else if (sts.scan_hit) begin
          state_nxt = sts.hit_urgent ? fwup_pkg::S_IDLE : fwup_pkg::S_MOVE;
        end else begin
          ctl.do_step = 1'b1;
        end
      end
      fwup_pkg::S_MOVE: begin
        ctl.do_move = 1'b1;
        state_nxt   = fwup_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fwup_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/fwup_dpath.sv]
// Queue cells, counters, match vector and result register of the landing queue.
// Driven by fwup_ctrl through fwup_ctl_t. Depends on fwup_pkg.
module fwup_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fwup_pkg::fwup_ctl_t             ctl,
  input  logic [fwup_pkg::CMD_W-1:0]      in_cmd,
  input  logic [fwup_pkg::FLIGHT_W-1:0]   in_flight,
  input  logic [fwup_pkg::ORIGIN_W-1:0]   in_origin,
  input  logic                            out_tready,
  output fwup_pkg::fwup_sts_t             sts,
  output logic                            out_valid,
  output logic [fwup_pkg::STATUS_W-1:0]   out_status,
  output logic [fwup_pkg::FLIGHT_W-1:0]   out_flight,
  output logic [fwup_pkg::ORIGIN_W-1:0]   out_origin
);

  localparam int DEPTH = fwup_pkg::QUEUE_DEPTH;
  localparam int CW    = fwup_pkg::CNT_W;
  localparam int IW    = fwup_pkg::IDX_W;
  localparam int FW    = fwup_pkg::FLIGHT_W;
  localparam int OW    = fwup_pkg::ORIGIN_W;

  logic [fwup_pkg::CMD_W-1:0] cmd_r;
  logic [FW-1:0]              flight_in_r;
  logic [OW-1:0]              origin_in_r;

  logic [FW-1:0] flight_r [DEPTH];
  logic [FW-1:0] flight_nxt [DEPTH];
  logic [OW-1:0] origin_r [DEPTH];
  logic [OW-1:0] origin_nxt [DEPTH];
  logic [DEPTH-1:0] match_r, match_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] urgent_r, urgent_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [fwup_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [FW-1:0]              out_flight_r, out_flight_nxt;
  logic [OW-1:0]              out_origin_r, out_origin_nxt;

  logic [FW-1:0] keep_flight;
  logic [OW-1:0] keep_origin;

  assign keep_flight = flight_r[idx_r[IW-1:0]];
  assign keep_origin = origin_r[idx_r[IW-1:0]];

  // queue cells
  always_comb begin
    flight_nxt = flight_r;
    origin_nxt = origin_r;
    if (ctl.do_arrive) begin
      flight_nxt[count_r[IW-1:0]] = flight_in_r;
      origin_nxt[count_r[IW-1:0]] = origin_in_r;
    end
    if (ctl.do_clear) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        flight_nxt[i] = flight_r[i+1];
        origin_nxt[i] = origin_r[i+1];
      end
    end
    if (ctl.do_move) begin
      for (int i = 1; i < DEPTH; i++) begin
        if (CW'(i) > urgent_r && CW'(i) <= idx_r) begin
          flight_nxt[i] = flight_r[i-1];
          origin_nxt[i] = origin_r[i-1];
        end
      end
      flight_nxt[urgent_r[IW-1:0]] = keep_flight;
      origin_nxt[urgent_r[IW-1:0]] = keep_origin;
    end
  end

  // per-cell compare against the requested flight
  always_comb begin
    match_nxt = match_r;
    if (ctl.do_match) begin
      for (int i = 0; i < DEPTH; i++) begin
        match_nxt[i] = (flight_r[i] == flight_in_r) && (CW'(i) < count_r);
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    urgent_nxt = urgent_r;
    idx_nxt    = idx_r;
    if (ctl.do_arrive) begin
      count_nxt = count_r + CW'(1);
    end
    if (ctl.do_clear) begin
      count_nxt = count_r - CW'(1);
      if (urgent_r != '0) begin
        urgent_nxt = urgent_r - CW'(1);
      end
    end
    if (ctl.do_match) begin
      idx_nxt = '0;
    end
    if (ctl.do_step) begin
      idx_nxt = idx_r + CW'(1);
    end
    if (ctl.do_move) begin
      urgent_nxt = urgent_r + CW'(1);
    end
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_flight_nxt = out_flight_r;
    out_origin_nxt = out_origin_r;
    if (ctl.do_drop || ctl.do_nobody || ctl.do_clear) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ctl.do_drop   ? fwup_pkg::ST_DROPPED :
                       ctl.do_nobody ? fwup_pkg::ST_NOBODY  : fwup_pkg::ST_LANDED;
      out_flight_nxt = ctl.do_clear ? flight_r[0] : '0;
      out_origin_nxt = ctl.do_clear ? origin_r[0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      urgent_r    <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      urgent_r    <= urgent_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r       <= in_cmd;
      flight_in_r <= in_flight;
      origin_in_r <= in_origin;
    end
    flight_r     <= flight_nxt;
    origin_r     <= origin_nxt;
    match_r      <= match_nxt;
    out_status_r <= out_status_nxt;
    out_flight_r <= out_flight_nxt;
    out_origin_r <= out_origin_nxt;
  end

  assign sts.cmd        = cmd_r;
  assign sts.full       = (count_r == CW'(DEPTH));
  assign sts.empty      = (count_r == '0);
  assign sts.scan_end   = (idx_r == count_r);
  assign sts.scan_hit   = match_r[idx_r[IW-1:0]];
  assign sts.hit_urgent = (idx_r < urgent_r);
  assign sts.out_busy   = out_valid_r;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_flight = out_flight_r;
  assign out_origin = out_origin_r;

  a_urgent_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
    urgent_r <= count_r)
    else $error("urgent section longer than queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_move_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_move |-> (idx_r >= urgent_r) && (idx_r < count_r))
    else $error("promotion position outside queue body");

  a_clear_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_clear |=> (count_r == $past(count_r) - CW'(1)) && out_valid_r)
    else $error("runway clear did not remove head");

endmodule

[rtl/core/fifo_with_urgent_promotion.sv]
// Landing queue with urgent promotion: top level joining fwup_ctrl and fwup_dpath.
// Depends on fwup_pkg.
// Results: a dropped arrival or a clear registers a result in execute, held until taken;
//   other requests give none. Arrival and clear pass idle and execute; an urgent request
//   passes idle, execute and a scan of the entries, then move if the flight is promoted.
// Reset (synchronous, rst_n low): queue empty, no urgent entries, no result pending.
module fifo_with_urgent_promotion (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [13:0] flight_number, [29:14] origin_tag, [31:30] zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [13:0] landed_flight, [29:14] landed_origin, [31:30] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  fwup_pkg::fwup_ctl_t ctl;
  fwup_pkg::fwup_sts_t sts;

  logic [fwup_pkg::FLIGHT_W-1:0] out_flight;
  logic [fwup_pkg::ORIGIN_W-1:0] out_origin;

  fwup_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .ctl        (ctl)
  );

  fwup_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_cmd     (in_tuser),
    .in_flight  (in_tdata[13:0]),
    .in_origin  (in_tdata[29:14]),
    .out_tready (out_tready),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_flight (out_flight),
    .out_origin (out_origin)
  );

  assign out_tdata = {2'b00, out_origin, out_flight};

endmodule
